// ===== hw/rtl/stok_pkg.sv =====
package stok_pkg;

  localparam int MAX_LEXEME    = 32;
  localparam int CNT_W         = $clog2(MAX_LEXEME + 1);
  localparam int KEYWORD_COUNT = 28;
  localparam int KW_W          = $clog2(KEYWORD_COUNT);
  localparam int KW_MAXLEN     = 9;
  localparam int CAT_W         = 6;
  localparam int LINE_W        = 16;

  localparam logic [CAT_W-1:0] CAT_IDENT  = 6'd0;
  localparam logic [CAT_W-1:0] CAT_INT    = 6'd1;
  localparam logic [CAT_W-1:0] CAT_CHAR   = 6'd2;
  localparam logic [CAT_W-1:0] CAT_STRING = 6'd3;
  localparam logic [CAT_W-1:0] CAT_KW0    = 6'd4;
  localparam logic [CAT_W-1:0] CAT_SEMI   = 6'd32;
  localparam logic [CAT_W-1:0] CAT_COMMA  = 6'd33;
  localparam logic [CAT_W-1:0] CAT_PLUS   = 6'd34;
  localparam logic [CAT_W-1:0] CAT_MINUS  = 6'd35;
  localparam logic [CAT_W-1:0] CAT_STAR   = 6'd36;
  localparam logic [CAT_W-1:0] CAT_SLASH  = 6'd37;
  localparam logic [CAT_W-1:0] CAT_CARET  = 6'd38;
  localparam logic [CAT_W-1:0] CAT_VEE    = 6'd39;
  localparam logic [CAT_W-1:0] CAT_TILDE  = 6'd40;
  localparam logic [CAT_W-1:0] CAT_LPAREN = 6'd41;
  localparam logic [CAT_W-1:0] CAT_RPAREN = 6'd42;
  localparam logic [CAT_W-1:0] CAT_LBRACK = 6'd43;
  localparam logic [CAT_W-1:0] CAT_RBRACK = 6'd44;
  localparam logic [CAT_W-1:0] CAT_ASSIGN = 6'd45;
  localparam logic [CAT_W-1:0] CAT_COLON  = 6'd46;
  localparam logic [CAT_W-1:0] CAT_RANGE  = 6'd47;
  localparam logic [CAT_W-1:0] CAT_ARROW  = 6'd48;
  localparam logic [CAT_W-1:0] CAT_EQ     = 6'd49;
  localparam logic [CAT_W-1:0] CAT_LE     = 6'd50;
  localparam logic [CAT_W-1:0] CAT_NE     = 6'd51;
  localparam logic [CAT_W-1:0] CAT_LT     = 6'd52;
  localparam logic [CAT_W-1:0] CAT_GE     = 6'd53;
  localparam logic [CAT_W-1:0] CAT_GT     = 6'd54;
  localparam logic [CAT_W-1:0] CAT_END    = 6'd55;
  localparam logic [CAT_W-1:0] CAT_ERROR  = 6'd56;

  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KEYWORD_COUNT] = '{
    "bool", "char", "int", "if", "else", "while", "loop", "until",
    "for", "to", "step", "do", "match", "when", "otherwise",
    "start", "end", "globals", "locals", "fn", "proc", "ret",
    "print", "scan", "true", "false", "module", "main"
  };
  localparam int KW_LEN [KEYWORD_COUNT] = '{
    4, 4, 3, 2, 4, 5, 4, 5, 3, 2, 4, 2, 5, 4, 9,
    5, 3, 7, 6, 2, 4, 3, 5, 4, 4, 5, 6, 4
  };

  typedef enum logic [12:0] {
    SC_START     = 13'b0000000000001,
    SC_IDENT     = 13'b0000000000010,
    SC_NUMBER    = 13'b0000000000100,
    SC_STRING    = 13'b0000000001000,
    SC_COLON     = 13'b0000000010000,
    SC_DOT       = 13'b0000000100000,
    SC_EQUAL     = 13'b0000001000000,
    SC_LESS      = 13'b0000010000000,
    SC_GREATER   = 13'b0000100000000,
    SC_AT        = 13'b0001000000000,
    SC_LINE_CMT  = 13'b0010000000000,
    SC_BLOCK     = 13'b0100000000000,
    SC_BLOCK_BRC = 13'b1000000000000
  } scan_t;

  typedef struct packed {
    logic [CAT_W-1:0]  cat;
    logic [LINE_W-1:0] line;
    logic [CNT_W-1:0]  len;
    logic [7:0]        ch;
  } tok_t;

  typedef struct packed {
    logic             clear;
    logic             push;
    logic [CNT_W-1:0] pos;
    logic [7:0]       ch;
    logic [CNT_W-1:0] len;
  } kw_ctl_t;

  function automatic logic [7:0] kw_char(int k, logic [CNT_W-1:0] p);
    logic [8*KW_MAXLEN-1:0] t;
    int l;
    t = KW_TEXT[k];
    l = KW_LEN[k];
    if (int'(p) < l) kw_char = t[8*(l-1-int'(p)) +: 8];
    else kw_char = 8'd0;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [CAT_W-1:0] single_symbol(logic [7:0] c);
    logic [CAT_W-1:0] r;
    unique case (c)
      ";":     r = CAT_SEMI;
      ",":     r = CAT_COMMA;
      "+":     r = CAT_PLUS;
      "-":     r = CAT_MINUS;
      "*":     r = CAT_STAR;
      "/":     r = CAT_SLASH;
      "^":     r = CAT_CARET;
      "v":     r = CAT_VEE;
      "~":     r = CAT_TILDE;
      "(":     r = CAT_LPAREN;
      ")":     r = CAT_RPAREN;
      "[":     r = CAT_LBRACK;
      "]":     r = CAT_RBRACK;
      default: r = CAT_ERROR;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/source_tokenizer.sv =====
// Source tokenizer: takes one source byte per input transaction (or an
// end-of-input mark) and returns zero, one or two token transactions, the
// last of which carries out_last_of_run. An input is first accepted and
// then evaluated; each of its tokens is then offered in turn and held while
// the output side is not ready. The sequencer is busy until all tokens of
// the input have been taken. Keyword recognition is done incrementally as
// identifier characters arrive, so identifier ends cost nothing extra.
module source_tokenizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_char_code,
  input  logic                          in_end_of_input,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stok_pkg::CAT_W-1:0]    out_category,
  output logic [stok_pkg::LINE_W-1:0]   out_line_number,
  output logic [stok_pkg::CNT_W-1:0]    out_lexeme_length,
  output logic [7:0]                    out_token_char,
  output logic                          out_last_of_run
);
  import stok_pkg::*;

  // Sequencer: wait for a byte, evaluate it, then present its tokens.
  typedef enum logic [3:0] {
    SQ_IDLE = 4'b0001,
    SQ_EVAL = 4'b0010,
    SQ_OUT0 = 4'b0100,
    SQ_OUT1 = 4'b1000
  } seq_t;

  seq_t              seq_r, seq_nxt;
  scan_t             scan_r, scan_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LINE_W-1:0] line_r, line_nxt, sline_r, sline_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [7:0]        ch_r;
  logic              eoi_r;
  tok_t              t0_r, t1_r;
  logic              two_r;

  tok_t              a_tok, b_tok;
  logic              a_vld, b_vld, again, push;
  logic [CNT_W-1:0]  pos;
  logic              kw_clear, kw_hit;
  logic [KW_W-1:0]   kw_idx;
  kw_ctl_t           kw_ctl;
  logic [CAT_W-1:0]  kw_cat;
  logic [7:0]        fch, c;
  logic [LINE_W-1:0] line_inc;

  stok_kwmatch u_kw (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (kw_ctl),
    .hit   (kw_hit),
    .idx   (kw_idx)
  );

  assign c        = ch_r;
  assign fch      = (cnt_r != '0) ? first_r : 8'd0;
  assign kw_cat   = (!ovf_r && kw_hit) ? (CAT_KW0 + CAT_W'(kw_idx)) : CAT_IDENT;
  assign line_inc = (line_r != {LINE_W{1'b1}}) ? line_r + 1'b1 : line_r;

  // Evaluation of one byte: phase A finishes the pending token, phase B
  // starts a new one when the byte has to be scanned again.
  always_comb begin
    scan_nxt  = scan_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    line_nxt  = line_r;
    sline_nxt = sline_r;
    first_nxt = first_r;
    a_vld     = 1'b0;
    b_vld     = 1'b0;
    a_tok     = '0;
    b_tok     = '0;
    again     = 1'b0;
    push      = 1'b0;
    pos       = cnt_r;
    kw_clear  = 1'b0;

    if (eoi_r) begin
      a_vld = 1'b1;
      unique case (scan_r)
        SC_IDENT:   a_tok = '{kw_cat, sline_r, cnt_r, fch};
        SC_NUMBER:  a_tok = '{CAT_INT, sline_r, cnt_r, fch};
        SC_COLON:   a_tok = '{CAT_COLON, sline_r, CNT_W'(1), ":"};
        SC_EQUAL:   a_tok = '{CAT_EQ, sline_r, CNT_W'(1), "="};
        SC_LESS:    a_tok = '{CAT_LT, sline_r, CNT_W'(1), "<"};
        SC_GREATER: a_tok = '{CAT_GT, sline_r, CNT_W'(1), ">"};
        SC_STRING, SC_DOT, SC_BLOCK, SC_BLOCK_BRC:
                    a_tok = '{CAT_ERROR, sline_r, CNT_W'(1), 8'd0};
        default:    a_vld = 1'b0;
      endcase
      b_vld    = 1'b1;
      b_tok    = '{CAT_END, line_r, CNT_W'(0), 8'd0};
      scan_nxt = SC_START;
    end else begin
      unique case (scan_r)
        SC_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") push = 1'b1;
          else begin
            a_vld = 1'b1; a_tok = '{kw_cat, sline_r, cnt_r, fch}; again = 1'b1;
          end
        end
        SC_NUMBER: begin
          if (is_digit(c)) push = 1'b1;
          else begin
            a_vld = 1'b1; a_tok = '{CAT_INT, sline_r, cnt_r, fch}; again = 1'b1;
          end
        end
        SC_STRING: begin
          if (c == "'") begin
            a_vld = 1'b1;
            a_tok = '{(cnt_r == CNT_W'(1) && !ovf_r) ? CAT_CHAR : CAT_STRING,
                      sline_r, cnt_r, fch};
            scan_nxt = SC_START;
          end else if (c == 8'd10) begin
            a_vld = 1'b1; a_tok = '{CAT_ERROR, sline_r, CNT_W'(1), c};
            scan_nxt = SC_START;
          end else push = 1'b1;
        end
        SC_COLON: begin
          a_vld = 1'b1;
          if (c == "=") begin
            a_tok = '{CAT_ASSIGN, sline_r, CNT_W'(2), ":"}; scan_nxt = SC_START;
          end else begin
            a_tok = '{CAT_COLON, sline_r, CNT_W'(1), ":"}; again = 1'b1;
          end
        end
        SC_DOT: begin
          a_vld = 1'b1;
          if (c == ".") begin
            a_tok = '{CAT_RANGE, sline_r, CNT_W'(2), "."}; scan_nxt = SC_START;
          end else begin
            a_tok = '{CAT_ERROR, sline_r, CNT_W'(1), c}; again = 1'b1;
          end
        end
        SC_EQUAL: begin
          a_vld = 1'b1;
          if (c == ">") begin
            a_tok = '{CAT_ARROW, sline_r, CNT_W'(2), "="}; scan_nxt = SC_START;
          end else begin
            a_tok = '{CAT_EQ, sline_r, CNT_W'(1), "="}; again = 1'b1;
          end
        end
        SC_LESS: begin
          a_vld = 1'b1;
          if (c == "=") begin
            a_tok = '{CAT_LE, sline_r, CNT_W'(2), "<"}; scan_nxt = SC_START;
          end else if (c == ">") begin
            a_tok = '{CAT_NE, sline_r, CNT_W'(2), "<"}; scan_nxt = SC_START;
          end else begin
            a_tok = '{CAT_LT, sline_r, CNT_W'(1), "<"}; again = 1'b1;
          end
        end
        SC_GREATER: begin
          a_vld = 1'b1;
          if (c == "=") begin
            a_tok = '{CAT_GE, sline_r, CNT_W'(2), ">"}; scan_nxt = SC_START;
          end else begin
            a_tok = '{CAT_GT, sline_r, CNT_W'(1), ">"}; again = 1'b1;
          end
        end
        SC_AT, SC_LINE_CMT: begin
          if (scan_r == SC_AT && c == "{") scan_nxt = SC_BLOCK;
          else if (c == 8'd10) begin
            line_nxt = line_inc; scan_nxt = SC_START;
          end else scan_nxt = SC_LINE_CMT;
        end
        SC_BLOCK, SC_BLOCK_BRC: begin
          if (scan_r == SC_BLOCK_BRC && c == "@") scan_nxt = SC_START;
          else begin
            if (c == 8'd10) line_nxt = line_inc;
            scan_nxt = (c == "}") ? SC_BLOCK_BRC : SC_BLOCK;
          end
        end
        default: again = 1'b1;
      endcase

      // Start of a new token from the start state.
      if (again) begin
        scan_nxt = SC_START;
        if (is_space(c)) begin
          if (c == 8'd10) line_nxt = line_inc;
        end else begin
          sline_nxt = line_r;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          kw_clear  = 1'b1;
          pos       = '0;
          priority if (c == "@") scan_nxt = SC_AT;
          else if (is_alpha(c) || c == "_") begin
            push = 1'b1; scan_nxt = SC_IDENT;
          end else if (is_digit(c)) begin
            push = 1'b1; scan_nxt = SC_NUMBER;
          end
          else if (c == "'") scan_nxt = SC_STRING;
          else if (c == ":") scan_nxt = SC_COLON;
          else if (c == ".") scan_nxt = SC_DOT;
          else if (c == "=") scan_nxt = SC_EQUAL;
          else if (c == "<") scan_nxt = SC_LESS;
          else if (c == ">") scan_nxt = SC_GREATER;
          else begin
            b_vld = 1'b1; b_tok = '{single_symbol(c), line_r, CNT_W'(1), c};
          end
        end
      end

      // Only the first character of a lexeme is ever reported, so the
      // lexeme text is kept as its first character and its length.
      if (push) begin
        if (int'(pos) < MAX_LEXEME) begin
          if (pos == '0) first_nxt = c;
          cnt_nxt = pos + 1'b1;
        end else ovf_nxt = 1'b1;
      end
    end
  end

  assign kw_ctl = '{clear: kw_clear && seq_r == SQ_EVAL,
                    push:  push && seq_r == SQ_EVAL,
                    pos:   pos, ch: c, len: cnt_r};

  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      SQ_IDLE: if (in_valid) seq_nxt = SQ_EVAL;
      SQ_EVAL: seq_nxt = (a_vld || b_vld) ? SQ_OUT0 : SQ_IDLE;
      SQ_OUT0: if (out_ready) seq_nxt = two_r ? SQ_OUT1 : SQ_IDLE;
      SQ_OUT1: if (out_ready) seq_nxt = SQ_IDLE;
      default: seq_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= SQ_IDLE;
      scan_r  <= SC_START;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      line_r  <= LINE_W'(1);
      sline_r <= LINE_W'(1);
      two_r   <= 1'b0;
    end else begin
      seq_r <= seq_nxt;
      if (seq_r == SQ_EVAL) begin
        scan_r  <= scan_nxt;
        cnt_r   <= cnt_nxt;
        ovf_r   <= ovf_nxt;
        line_r  <= line_nxt;
        sline_r <= sline_nxt;
        two_r   <= a_vld && b_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seq_r == SQ_IDLE && in_valid) begin
      ch_r  <= in_char_code;
      eoi_r <= in_end_of_input;
    end
    if (seq_r == SQ_EVAL) begin
      first_r <= first_nxt;
      t0_r    <= a_vld ? a_tok : b_tok;
      t1_r    <= b_tok;
    end
  end

  assign in_ready          = (seq_r == SQ_IDLE);
  assign out_valid         = (seq_r == SQ_OUT0) || (seq_r == SQ_OUT1);
  assign out_category      = (seq_r == SQ_OUT1) ? t1_r.cat  : t0_r.cat;
  assign out_line_number   = (seq_r == SQ_OUT1) ? t1_r.line : t0_r.line;
  assign out_lexeme_length = (seq_r == SQ_OUT1) ? t1_r.len  : t0_r.len;
  assign out_token_char    = (seq_r == SQ_OUT1) ? t1_r.ch   : t0_r.ch;
  assign out_last_of_run   = (seq_r == SQ_OUT1) || !two_r;

  // The block never offers a token while it can take a new byte.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("token offered while idle");

  // After the last token of a run the block is ready again.
  a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_of_run) |=> in_ready)
    else $error("not ready after last token");

  // The lexeme length never exceeds the buffer size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= MAX_LEXEME) else $error("lexeme count out of range");

  // The line counter never wraps to zero.
  a_line_nz: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0) else $error("line counter wrapped");

endmodule

// ===== hw/rtl/stok_kwmatch.sv =====
module stok_kwmatch (
  input  logic                        clk,
  input  logic                        rst_n,
  input  stok_pkg::kw_ctl_t           ctl,
  output logic                        hit,
  output logic [stok_pkg::KW_W-1:0]   idx
);
  import stok_pkg::*;

  // One bit per keyword: still a prefix match of the word so far.
  logic [KEYWORD_COUNT-1:0] mask_r, mask_nxt, hit_v;

  always_comb begin
    logic b;
    idx = '0;
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      b = ctl.clear ? 1'b1 : mask_r[k];
      if (ctl.push) begin
        b = b && (int'(ctl.pos) < KW_LEN[k]) && (kw_char(k, ctl.pos) == ctl.ch);
      end
      mask_nxt[k] = b;
      hit_v[k] = mask_r[k] && (ctl.len == CNT_W'(KW_LEN[k]));
      if (hit_v[k]) idx = idx | KW_W'(k);
    end
    hit = |hit_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

endmodule

// ===== tb/sv/source_tokenizer_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the source tokenizer. An initial block writes source
// text into a queue of pending characters. A clocked driver offers them in
// bursts, and each accepted transaction runs through the scanner model below.
// The model appends the tokens it predicts to a queue. A clocked monitor checks
// every token the block returns against the oldest prediction.
module source_tokenizer_tb;
  import stok_pkg::*;

  localparam int LIMIT_CYCLES = 200000;

  typedef struct {
    logic [7:0] code;
    logic       eoi;
    logic       drain;  // Hold the sender until all predicted tokens are back.
  } src_item_t;

  typedef struct {
    logic [CAT_W-1:0]  cat;
    logic [LINE_W-1:0] line;
    logic [CNT_W-1:0]  len;
    logic [7:0]        ch;
    logic              last;
  } token_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_char_code = 8'd0;
  logic in_end_of_input = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CAT_W-1:0] out_category;
  logic [LINE_W-1:0] out_line_number;
  logic [CNT_W-1:0] out_lexeme_length;
  logic [7:0] out_token_char;
  logic out_last_of_run;

  src_item_t src_bytes[$];
  token_t expected_tokens[$];
  int n_errors = 0;
  int n_chars_sent = 0;
  int n_tokens_seen = 0;
  int n_keywords_seen = 0;
  int n_error_tokens = 0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  source_tokenizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char_code(in_char_code), .in_end_of_input(in_end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_category(out_category), .out_line_number(out_line_number),
    .out_lexeme_length(out_lexeme_length), .out_token_char(out_token_char),
    .out_last_of_run(out_last_of_run)
  );

  // ---------------------------------------------------------------------------
  // Scanner model. It keeps its own copy of the scanner state, the lexeme
  // buffer and the line counters.
  // ---------------------------------------------------------------------------
  scan_t             lx_state = SC_START;
  logic [7:0]        lx_buf [MAX_LEXEME];
  int                lx_count = 0;
  bit                lx_overflow = 1'b0;
  logic [LINE_W-1:0] lx_line = 16'd1;
  logic [LINE_W-1:0] lx_start_line = 16'd1;
  int                lx_emitted = 0;

  function automatic bit blank_char(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit letter_char(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function void count_line();
    if (lx_line != 16'hFFFF) lx_line = lx_line + 16'd1;
  endfunction

  function void buffer_char(logic [7:0] c);
    if (lx_count < MAX_LEXEME) begin
      lx_buf[lx_count] = c;
      lx_count++;
    end else begin
      lx_overflow = 1'b1;
    end
  endfunction

  function logic [7:0] lead_char();
    return lx_count > 0 ? lx_buf[0] : 8'd0;
  endfunction

  // At most two tokens can come from one character.
  function void predict_token(logic [CAT_W-1:0] cat, logic [LINE_W-1:0] line, int len,
                              logic [7:0] ch);
    token_t t;
    if (lx_emitted >= 2) return;
    t.cat = cat;
    t.line = line;
    t.len = CNT_W'(len);
    t.ch = ch;
    t.last = 1'b0;
    expected_tokens.push_back(t);
    lx_emitted++;
  endfunction

  // A keyword must fit in the buffer exactly. An identifier that overflowed the
  // buffer is never a keyword.
  function logic [CAT_W-1:0] word_category();
    logic [8*KW_MAXLEN-1:0] text;
    bit same;
    if (lx_overflow) return CAT_IDENT;
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      if (KW_LEN[k] == lx_count) begin
        text = KW_TEXT[k];
        same = 1'b1;
        for (int i = 0; i < lx_count; i++)
          if (lx_buf[i] != text[8*(lx_count-1-i) +: 8]) same = 1'b0;
        if (same) return CAT_KW0 + CAT_W'(k);
      end
    end
    return CAT_IDENT;
  endfunction

  function logic [CAT_W-1:0] symbol_category(logic [7:0] c);
    case (c)
      ";": return CAT_SEMI;
      ",": return CAT_COMMA;
      "+": return CAT_PLUS;
      "-": return CAT_MINUS;
      "*": return CAT_STAR;
      "/": return CAT_SLASH;
      "^": return CAT_CARET;
      "~": return CAT_TILDE;
      "(": return CAT_LPAREN;
      ")": return CAT_RPAREN;
      "[": return CAT_LBRACK;
      "]": return CAT_RBRACK;
      default: return CAT_ERROR;
    endcase
  endfunction

  // Handles a character seen in the start state, including a character that is
  // seen again after it ended the previous token.
  function void start_token(logic [7:0] c);
    lx_state = SC_START;
    if (blank_char(c)) begin
      if (c == 8'd10) count_line();
      return;
    end
    lx_start_line = lx_line;
    lx_count = 0;
    lx_overflow = 1'b0;
    if (c == "@") lx_state = SC_AT;
    else if (letter_char(c) || c == "_") begin
      buffer_char(c);
      lx_state = SC_IDENT;
    end else if (digit_char(c)) begin
      buffer_char(c);
      lx_state = SC_NUMBER;
    end else if (c == "'") lx_state = SC_STRING;
    else if (c == ":") lx_state = SC_COLON;
    else if (c == ".") lx_state = SC_DOT;
    else if (c == "=") lx_state = SC_EQUAL;
    else if (c == "<") lx_state = SC_LESS;
    else if (c == ">") lx_state = SC_GREATER;
    else predict_token(symbol_category(c), lx_start_line, 1, c);
  endfunction

  function void block_comment_char(logic [7:0] c);
    if (c == 8'd10) count_line();
    lx_state = (c == "}") ? SC_BLOCK_BRC : SC_BLOCK;
  endfunction

  function void lex_step(logic [7:0] c, logic eoi);
    bit again;
    again = 1'b0;
    lx_emitted = 0;
    if (eoi) begin
      // Flush whatever is open, then close with the end token.
      case (lx_state)
        SC_IDENT:   predict_token(word_category(), lx_start_line, lx_count, lead_char());
        SC_NUMBER:  predict_token(CAT_INT, lx_start_line, lx_count, lead_char());
        SC_COLON:   predict_token(CAT_COLON, lx_start_line, 1, ":");
        SC_EQUAL:   predict_token(CAT_EQ, lx_start_line, 1, "=");
        SC_LESS:    predict_token(CAT_LT, lx_start_line, 1, "<");
        SC_GREATER: predict_token(CAT_GT, lx_start_line, 1, ">");
        SC_STRING, SC_DOT, SC_BLOCK, SC_BLOCK_BRC:
          predict_token(CAT_ERROR, lx_start_line, 1, 8'd0);
        default: ;
      endcase
      predict_token(CAT_END, lx_line, 0, 8'd0);
      lx_state = SC_START;
    end else begin
      case (lx_state)
        SC_IDENT:
          if (letter_char(c) || digit_char(c) || c == "_") buffer_char(c);
          else begin
            predict_token(word_category(), lx_start_line, lx_count, lead_char());
            again = 1'b1;
          end
        SC_NUMBER:
          if (digit_char(c)) buffer_char(c);
          else begin
            predict_token(CAT_INT, lx_start_line, lx_count, lead_char());
            again = 1'b1;
          end
        SC_STRING:
          if (c == "'") begin
            // Exactly one quoted character is a char constant.
            predict_token((lx_count == 1 && !lx_overflow) ? CAT_CHAR : CAT_STRING,
                          lx_start_line, lx_count, lead_char());
            lx_state = SC_START;
          end else if (c == 8'd10) begin
            // A newline breaks the string and is not counted as a line.
            predict_token(CAT_ERROR, lx_start_line, 1, c);
            lx_state = SC_START;
          end else buffer_char(c);
        SC_COLON:
          if (c == "=") begin
            predict_token(CAT_ASSIGN, lx_start_line, 2, ":");
            lx_state = SC_START;
          end else begin
            predict_token(CAT_COLON, lx_start_line, 1, ":");
            again = 1'b1;
          end
        SC_DOT:
          if (c == ".") begin
            predict_token(CAT_RANGE, lx_start_line, 2, ".");
            lx_state = SC_START;
          end else begin
            // A lone dot reports the character that follows it.
            predict_token(CAT_ERROR, lx_start_line, 1, c);
            again = 1'b1;
          end
        SC_EQUAL:
          if (c == ">") begin
            predict_token(CAT_ARROW, lx_start_line, 2, "=");
            lx_state = SC_START;
          end else begin
            predict_token(CAT_EQ, lx_start_line, 1, "=");
            again = 1'b1;
          end
        SC_LESS:
          if (c == "=" || c == ">") begin
            predict_token(c == "=" ? CAT_LE : CAT_NE, lx_start_line, 2, "<");
            lx_state = SC_START;
          end else begin
            predict_token(CAT_LT, lx_start_line, 1, "<");
            again = 1'b1;
          end
        SC_GREATER:
          if (c == "=") begin
            predict_token(CAT_GE, lx_start_line, 2, ">");
            lx_state = SC_START;
          end else begin
            predict_token(CAT_GT, lx_start_line, 1, ">");
            again = 1'b1;
          end
        SC_AT, SC_LINE_CMT:
          if (lx_state == SC_AT && c == "{") lx_state = SC_BLOCK;
          else if (c == 8'd10) begin
            count_line();
            lx_state = SC_START;
          end else lx_state = SC_LINE_CMT;
        SC_BLOCK:
          block_comment_char(c);
        SC_BLOCK_BRC:
          if (c == "@") lx_state = SC_START;
          else block_comment_char(c);
        default:
          start_token(c);
      endcase
      if (again) start_token(c);
    end
    if (lx_emitted > 0) expected_tokens[expected_tokens.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function void add_char(logic [7:0] c);
    src_item_t it;
    it.code = c;
    it.eoi = 1'b0;
    it.drain = 1'b0;
    src_bytes.push_back(it);
  endfunction

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  // The character code is random here to show that it is ignored.
  function void add_end();
    src_item_t it;
    it.code = 8'($urandom);
    it.eoi = 1'b1;
    it.drain = 1'b0;
    src_bytes.push_back(it);
  endfunction

  function void add_drain();
    src_item_t it;
    it.code = 8'd0;
    it.eoi = 1'b0;
    it.drain = 1'b1;
    src_bytes.push_back(it);
  endfunction

  function automatic logic [7:0] random_word_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h41, 8'h5a));
      1: return 8'($urandom_range(8'h30, 8'h39));
      2: return "_";
      default: return 8'($urandom_range(8'h61, 8'h7a));
    endcase
  endfunction

  function void add_keyword(int k);
    logic [8*KW_MAXLEN-1:0] text;
    text = KW_TEXT[k];
    for (int i = 0; i < KW_LEN[k]; i++) add_char(text[8*(KW_LEN[k]-1-i) +: 8]);
  endfunction

  // Identifiers are mostly short. A few run past the buffer size.
  function void add_identifier();
    int len;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(MAX_LEXEME - 1, MAX_LEXEME + 6)
                                       : $urandom_range(1, 7);
    add_char(($urandom_range(0, 4) == 0) ? 8'("_") : 8'($urandom_range(8'h61, 8'h7a)));
    for (int i = 1; i < len; i++) add_char(random_word_char());
  endfunction

  // A character that could sit inside a quoted constant: anything except the
  // quote itself, with a rare newline to break the string.
  function automatic logic [7:0] random_quoted_char();
    logic [7:0] c;
    if ($urandom_range(0, 30) == 0) return 8'd10;
    do c = 8'($urandom_range(8'h20, 8'hff)); while (c == "'");
    return c;
  endfunction

  function void add_random_token();
    string ops [18] = '{";", ",", "+", "-", "*", "/", "^", "~", "(", ")", "[", "]",
                        ":=", ":", "..", "=>", "=", "<="};
    string rel [5] = '{"<>", "<", ">=", ">", "="};
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2: add_keyword($urandom_range(0, KEYWORD_COUNT - 1));
      3, 4, 5: add_identifier();
      6, 7: begin
        n = ($urandom_range(0, 20) == 0) ? MAX_LEXEME + 3 : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) add_char(8'($urandom_range(8'h30, 8'h39)));
      end
      8: begin
        add_char("'");
        add_char(random_quoted_char());
        add_char("'");
      end
      9: begin
        n = ($urandom_range(0, 10) == 0) ? $urandom_range(MAX_LEXEME - 2, MAX_LEXEME + 4)
                                         : $urandom_range(0, 5);
        add_char("'");
        for (int i = 0; i < n; i++) add_char(random_quoted_char());
        add_char("'");
      end
      10, 11, 12: add_text(ops[$urandom_range(0, 17)]);
      13: add_text(rel[$urandom_range(0, 4)]);
      14: begin
        add_char("@");
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) add_char(8'($urandom_range(8'h20, 8'h7e)));
        add_char(8'd10);
      end
      15: begin
        // Block comment with stray braces, at signs and newlines inside.
        add_text("@{");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
          case ($urandom_range(0, 4))
            0: add_char("}");
            1: add_char("@");
            2: add_char(8'd10);
            default: add_char(8'($urandom_range(8'h20, 8'h7e)));
          endcase
        add_text("}@");
      end
      16: begin
        // A lone dot.
        add_char(".");
        add_char(8'($urandom_range(8'h20, 8'h7e)));
      end
      17: add_char(8'($urandom));
      18: add_char(8'($urandom_range(9, 13)));
      default: add_char(8'd10);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. The sender works in bursts of random length, with gaps between.
  // Valid stays high with the same payload until the block accepts it.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    logic next_valid;
    src_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        lex_step(in_char_code, in_end_of_input);
        n_chars_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        while (src_bytes.size() > 0 && src_bytes[0].drain && expected_tokens.size() == 0)
          void'(src_bytes.pop_front());
        if (gap_left > 0) begin
          gap_left--;
        end else if (src_bytes.size() > 0 && !src_bytes[0].drain) begin
          it = src_bytes.pop_front();
          in_char_code <= it.code;
          in_end_of_input <= it.eoi;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It switches between random stall modes now and then. Early in
  // the run it holds off for a long stretch, so the block backs up and stalls
  // its input while the sender keeps offering characters.
  // ---------------------------------------------------------------------------
  int rx_cycle = 0;
  int rx_mode = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
      if (rx_cycle >= 600 && rx_cycle < 900) out_ready <= 1'b0;
      else case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= (rx_cycle % 7 < 4);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each returned token with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_valid && out_ready) begin
      n_tokens_seen++;
      if (out_category >= CAT_KW0 && out_category < CAT_KW0 + KEYWORD_COUNT) n_keywords_seen++;
      if (out_category == CAT_ERROR) n_error_tokens++;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: category %0d line %0d", out_category, out_line_number);
        n_errors++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_category !== want.cat) begin
          $error("category: expected %0d, got %0d", want.cat, out_category);
          n_errors++;
        end
        if (out_line_number !== want.line) begin
          $error("line_number: expected %0d, got %0d", want.line, out_line_number);
          n_errors++;
        end
        if (out_lexeme_length !== want.len) begin
          $error("lexeme_length: expected %0d, got %0d", want.len, out_lexeme_length);
          n_errors++;
        end
        if (out_token_char !== want.ch) begin
          $error("token_char: expected %0d, got %0d", want.ch, out_token_char);
          n_errors++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
          n_errors++;
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("source_tokenizer_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test.
  // ---------------------------------------------------------------------------
  initial begin
    // Directed text: the longest keyword, the unreachable 'v' symbol, both
    // two-character operators around colon and dot, and a stray high byte. It
    // also has a char constant next to an empty string, the relational pairs,
    // a lone dot before a letter, a line comment, and a string left open at
    // the end of input.
    add_text("otherwise v:=0..");
    add_char(8'hFF);
    add_text("'a''' <=>=.x@c");
    add_char(8'd10);
    add_text("'q");
    add_end();
    add_drain();

    // Random text, mostly well-formed tokens. Separators are sometimes left
    // out, so a token can end on the first character of the next one.
    while (src_bytes.size() < 840) begin
      add_random_token();
      if ($urandom_range(0, 2) != 0) add_char(($urandom_range(0, 5) == 0) ? 8'd10 : 8'd32);
      if ($urandom_range(0, 60) == 0) add_end();
      if ($urandom_range(0, 120) == 0) add_drain();
    end
    add_text("@{ open");
    add_end();
    add_drain();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (src_bytes.size() == 0 && !in_valid);
    wait (expected_tokens.size() == 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d characters; %0d tokens checked (%0d keywords, %0d errors).",
             n_chars_sent, n_tokens_seen, n_keywords_seen, n_error_tokens);
    $display("Covered overlong lexemes, comments, broken strings, stalls and end marks.");
    if (n_errors == 0 && expected_tokens.size() == 0) begin
      $display("source_tokenizer_tb OK");
    end else begin
      $display("source_tokenizer_tb NOT OK");
    end
    $finish;
  end

endmodule
